@@ src/dq_pkg.sv @@
// shared types and constants for the double-ended queue
// used by dq_ctrl, dq_datapath and double_ended_queue; no dependencies

package dq_pkg;

    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                capture;
        logic                wr_en;
        logic                rd_en;
        logic                load;
        logic [STATUS_W-1:0] code;
    } t_dq_cmd;

    typedef struct packed {
        logic is_push;
        logic full;
        logic empty;
    } t_dq_stat;

endpackage

@@ src/double_ended_queue.sv @@
// double-ended queue top level: one request item in, one result item out
// each accepted request passes the capture, store access and result load steps of the
// controller in order, and no new request is taken until its result is loaded
// a result still held by the receiver stalls the next request in its load step
// reset (synchronous, active low) empties the queue and clears head, count and handshake state
// the ring store itself is not cleared; depends on dq_pkg, dq_ctrl and dq_datapath

module double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dq_pkg::S_DATA_W-1:0]   s_axis_tdata,  // push_value[31:0]
    input  logic [dq_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type[1:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dq_pkg::M_DATA_W-1:0]   m_axis_tdata,  // pop_value[31:0], occupancy[36:32], zeros
    output logic [dq_pkg::STATUS_W-1:0]   m_axis_tuser   // status[1:0]
);

    dq_pkg::t_dq_cmd  cmd;
    dq_pkg::t_dq_stat stat;

    logic [dq_pkg::VALUE_W-1:0]  pop_value;
    logic [dq_pkg::STATUS_W-1:0] status;
    logic [dq_pkg::OCC_W-1:0]    occupancy;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_pop_value (pop_value),
        .o_status    (status),
        .o_occupancy (occupancy)
    );

    assign m_axis_tdata = {3'b000, occupancy, pop_value};
    assign m_axis_tuser = status;

    // one request at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // refused requests return no word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != dq_pkg::ST_OK) |-> (pop_value == '0))
        else $error("refused request returned a word");

    // a push and a pop are never both issued
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("store written and read for one request");

    // no status code beyond the defined ones
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == dq_pkg::ST_OK) ||
                          (m_axis_tuser == dq_pkg::ST_FULL) ||
                          (m_axis_tuser == dq_pkg::ST_EMPTY))
        else $error("undefined status code on result");

endmodule

@@ src/dq_ctrl.sv @@
// controller state machine of the double-ended queue
// depends on dq_pkg for the command and status structs and codes

module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  dq_pkg::t_dq_stat i_stat,
    output dq_pkg::t_dq_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_LOAD   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.code  = dq_pkg::ST_OK;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (i_stat.is_push) begin
                    if (i_stat.full) begin
                        o_cmd.code = dq_pkg::ST_FULL;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.code = dq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/dq_datapath.sv @@
// datapath of the double-ended queue: ring store, head and count, result register
// depends on dq_pkg; driven by commands from dq_ctrl

module dq_datapath #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dq_pkg::REQ_W-1:0]      i_req,
    input  logic [dq_pkg::VALUE_W-1:0]    i_value,
    input  dq_pkg::t_dq_cmd               i_cmd,
    output dq_pkg::t_dq_stat              o_stat,
    output logic [dq_pkg::VALUE_W-1:0]    o_pop_value,
    output logic [dq_pkg::STATUS_W-1:0]   o_status,
    output logic [dq_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    logic [dq_pkg::REQ_W-1:0]    r_req;
    logic [dq_pkg::VALUE_W-1:0]  r_word;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic [WORD_BITS-1:0]        r_rd_data;
    logic                        r_popped;
    logic [dq_pkg::STATUS_W-1:0] r_code;
    logic [dq_pkg::VALUE_W-1:0]  r_out_pop;
    logic [dq_pkg::STATUS_W-1:0] r_out_status;
    logic [dq_pkg::OCC_W-1:0]    r_out_occ;

    logic [AW-1:0] head_prev;
    logic [AW-1:0] head_next;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] back_pos;
    logic [AW-1:0] last_pos;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign o_stat.is_push = r_req inside {dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK};
    assign o_stat.full    = (r_count == FULL_CNT);
    assign o_stat.empty   = (r_count == '0);

    always_comb begin
        head_prev = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
        head_next = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
        back_sum  = SW'(r_head) + SW'(r_count);
        last_sum  = back_sum - SW'(1);
        back_pos  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
        last_pos  = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
        wr_addr   = (r_req == dq_pkg::REQ_PUSH_FRONT) ? head_prev : back_pos;
        rd_addr   = (r_req == dq_pkg::REQ_POP_FRONT) ? r_head : last_pos;
    end

    // ring store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= WORD_BITS'(r_word);
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_count <= r_count + CW'(1);
                if (r_req == dq_pkg::REQ_PUSH_FRONT) begin
                    r_head <= head_prev;
                end
            end else if (i_cmd.rd_en) begin
                r_count <= r_count - CW'(1);
                if (r_req == dq_pkg::REQ_POP_FRONT) begin
                    r_head <= head_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req;
            r_word <= i_value;
        end
        if (i_cmd.wr_en || i_cmd.rd_en || i_cmd.code != dq_pkg::ST_OK) begin
            r_popped <= i_cmd.rd_en;
            r_code   <= i_cmd.code;
        end
        if (i_cmd.load) begin
            r_out_pop    <= r_popped ? dq_pkg::VALUE_W'(r_rd_data) : '0;
            r_out_status <= r_code;
            r_out_occ    <= dq_pkg::OCC_W'(r_count);
        end
    end

    assign o_pop_value = r_out_pop;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

endmodule

@@ bench/dq_checker.sv @@
`timescale 1ns / 100ps
// result checker for the double-ended queue: watches both streams, keeps its own
// ring, head and count, and compares every result item; depends on dq_pkg

module dq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [dq_pkg::S_DATA_W-1:0] i_s_tdata,   // push_value[31:0]
    input  logic [dq_pkg::REQ_W-1:0]    i_s_tuser,   // req_type[1:0]
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [dq_pkg::M_DATA_W-1:0] i_m_tdata,   // pop_value[31:0], occupancy[36:32], zeros
    input  logic [dq_pkg::STATUS_W-1:0] i_m_tuser,   // status[1:0]
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_requests,
    output int                          o_results,
    output int                          o_full_refusals,
    output int                          o_empty_refusals,
    output int                          o_peak_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [dq_pkg::VALUE_W-1:0]  pop_value;
        logic [dq_pkg::STATUS_W-1:0] status;
        logic [dq_pkg::OCC_W-1:0]    occupancy;
    } t_deque_result;

    t_deque_result              expected_results[$];
    logic [dq_pkg::VALUE_W-1:0] ring_copy [DEPTH];
    logic [IDX_W-1:0]           front_slot;
    int                         held_words;

    task automatic report_mismatch(input string what,
                                   input logic [dq_pkg::VALUE_W-1:0] got,
                                   input logic [dq_pkg::VALUE_W-1:0] want);
        $display("mismatch on result %0d: %s is 0x%08h, expected 0x%08h",
                 o_results, what, got, want);
        o_fail_count++;
    endtask

    task automatic apply_request(input logic [dq_pkg::REQ_W-1:0] req,
                                 input logic [dq_pkg::VALUE_W-1:0] word,
                                 output t_deque_result res);
        logic [IDX_W-1:0] slot;
        res = '0;
        res.status = dq_pkg::ST_OK;
        if (req == dq_pkg::REQ_PUSH_FRONT || req == dq_pkg::REQ_PUSH_BACK) begin
            if (held_words == DEPTH) begin
                res.status = dq_pkg::ST_FULL;
                o_full_refusals++;
            end else begin
                if (req == dq_pkg::REQ_PUSH_FRONT) begin
                    front_slot = front_slot - 1'b1;
                    slot = front_slot;
                end else begin
                    slot = front_slot + held_words[IDX_W-1:0];
                end
                ring_copy[slot] = word;
                held_words++;
            end
        end else begin
            if (held_words == 0) begin
                res.status = dq_pkg::ST_EMPTY;
                o_empty_refusals++;
            end else begin
                if (req == dq_pkg::REQ_POP_FRONT) begin
                    slot = front_slot;
                    front_slot = front_slot + 1'b1;
                end else begin
                    slot = front_slot + held_words[IDX_W-1:0] - 1'b1;
                end
                res.pop_value = ring_copy[slot];
                held_words--;
            end
        end
        res.occupancy = held_words[dq_pkg::OCC_W-1:0];
        if (held_words > o_peak_occupancy)
            o_peak_occupancy = held_words;
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result fresh;
        if (!i_rst_n) begin
            front_slot = '0;
            held_words = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", i_m_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_tdata[31:0] !== want.pop_value)
                        report_mismatch("pop_value", i_m_tdata[31:0], want.pop_value);
                    if (i_m_tuser !== want.status)
                        report_mismatch("status", 32'(i_m_tuser), 32'(want.status));
                    if (i_m_tdata[36:32] !== want.occupancy)
                        report_mismatch("occupancy", 32'(i_m_tdata[36:32]), 32'(want.occupancy));
                    if (i_m_tdata[39:37] !== 3'b000)
                        report_mismatch("padding", 32'(i_m_tdata[39:37]), '0);
                end
                o_results++;
            end
            if (i_s_tvalid === 1'b1 && i_s_tready === 1'b1) begin
                apply_request(i_s_tuser, i_s_tdata, fresh);
                expected_results.push_back(fresh);
                o_requests++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/double_ended_queue_tb.sv @@
`timescale 1ns / 100ps
// testbench top for double_ended_queue: reset, directed and random request items,
// random stalls on both streams and the verdict; depends on dq_pkg, dq_checker and double_ended_queue

module double_ended_queue_tb;

    localparam int DEPTH       = 16;
    localparam int RANDOM_REQS = 1330;
    localparam int CYCLE_LIMIT = 200000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [dq_pkg::S_DATA_W-1:0] s_axis_tdata;   // push_value[31:0]
    logic [dq_pkg::REQ_W-1:0]    s_axis_tuser;   // req_type[1:0]
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [dq_pkg::M_DATA_W-1:0] m_axis_tdata;   // pop_value[31:0], occupancy[36:32], zeros
    logic [dq_pkg::STATUS_W-1:0] m_axis_tuser;   // status[1:0]

    int fail_count, pending, requests, results;
    int full_refusals, empty_refusals, peak_occupancy;
    int cycle_count;
    bit sender_burst;
    bit receiver_burst;

    double_ended_queue #(.DEPTH(DEPTH), .WORD_BITS(dq_pkg::VALUE_W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tuser        (s_axis_tuser),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_requests       (requests),
        .o_results        (results),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals),
        .o_peak_occupancy (peak_occupancy)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [dq_pkg::REQ_W-1:0] req,
                                input logic [dq_pkg::VALUE_W-1:0] word);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [dq_pkg::VALUE_W-1:0] pick_word();
        logic [dq_pkg::VALUE_W-1:0] word;
        word = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: word = 32'h0000_0000;
                1: word = 32'hffff_ffff;
                2: word = 32'h7fff_ffff;
                default: word = 32'h8000_0000;
            endcase
        end
        return word;
    endfunction

    // result side: random stalls, one long hold-off to back the block up
    initial begin : result_drain
        int gap;
        int taken;
        taken = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 40 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            if (taken == 300)
                gap = 200;
            else
                gap = receiver_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : request_source
        int                       k;
        int                       phase_left;
        int                       push_pct;
        logic [dq_pkg::REQ_W-1:0] req;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dq_pkg::REQ_PUSH_FRONT;
        sender_burst  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // pops on an empty queue
        send_request(dq_pkg::REQ_POP_FRONT, 32'hffff_ffff);
        send_request(dq_pkg::REQ_POP_BACK, 32'h0000_0000);
        // extremes at both ends, front push wraps the head
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
        send_request(dq_pkg::REQ_POP_BACK, 32'h1234_5678);
        send_request(dq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'hffff_ffff);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(dq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(dq_pkg::REQ_POP_BACK, 32'h0);
        // fill to the top, then refused pushes at both ends
        for (k = 0; k < DEPTH; k++)
            send_request(k[0] ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT,
                         k[0] ? 32'haaaa_aaaa ^ k : 32'h5555_5555 ^ k);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h0bad_cafe);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'h0bad_cafe);

        // random phases leaning towards filling, draining or neither
        phase_left = 0;
        push_pct   = 50;
        for (k = 0; k < RANDOM_REQS; k++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_pct)
                req = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
            else
                req = $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
            send_request(req, pick_word());
        end
        @(negedge i_clk) s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d requests and %0d results with stalls on both sides",
                 requests, results);
        $display("%0d pushes refused when full, %0d pops refused when empty, peak occupancy %0d",
                 full_refusals, empty_refusals, peak_occupancy);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
bench/dq_checker.sv
bench/double_ended_queue_tb.sv
